// ----- hdl/ucbsel_pkg.sv -----
// shared types and constants for the ucb1 child selection block
`default_nettype none
package ucbsel_pkg;

    localparam int MAX_CHILDREN = 64;
    localparam int POS_W        = $clog2(MAX_CHILDREN + 1);
    localparam int IDX_W        = 6;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0]        GAIN_RESET      = 16'd5793;
    localparam logic signed [31:0] THRESHOLD_START = -32'sd65536;
    localparam logic signed [31:0] SCORE_MAX       = 32'sh7fff_ffff;
    localparam logic [31:0]        LN2_Q32         = 32'd2977044472;

    typedef struct packed {
        logic [15:0]        parent_visits;
        logic signed [15:0] child_wins;
        logic [15:0]        child_visits;
        logic               last_child;
    } child_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]   best_index;
        logic               best_unvisited;
        logic signed [31:0] best_score;
    } result_beat_t;

    typedef struct packed {
        child_beat_t      beat;
        logic             compare_en;
        logic             unvisited;
        logic             small_parent;
        logic [IDX_W-1:0] position;
    } job_t;

endpackage
`default_nettype wire

// ----- hdl/ucbsel_front.sv -----
// input side: child numbering, classification and job queue
`default_nettype none
module ucbsel_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ucbsel_pkg::child_beat_t s_data,
    output logic                      job_valid,
    input  wire logic                 job_ready,
    output ucbsel_pkg::job_t          job
);
    import ucbsel_pkg::*;

    job_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [POS_W-1:0]  pos_reg;
    job_t              entry;
    logic              push;
    logic              pop;

    assign s_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_valid && job_ready;

    always_comb begin
        entry              = '0;
        entry.beat         = s_data;
        entry.compare_en   = (pos_reg < POS_W'(MAX_CHILDREN));
        entry.unvisited    = (s_data.child_visits == '0);
        entry.small_parent = (s_data.parent_visits < 16'd2);
        entry.position     = pos_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
                if (s_data.last_child) begin
                    pos_reg <= '0;
                end else if (pos_reg < POS_W'(MAX_CHILDREN)) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ucbsel_div.sv -----
// shared restoring divider, 32 by 16 bits, one quotient bit per cycle
`default_nettype none
module ucbsel_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[31]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[15:0] : rem_sh[15:0];
                quo_reg <= {quo_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ucbsel_back.sv -----
// scoring sequencer: exploit, log, ratio, root, explore, best tracking
`default_nettype none
module ucbsel_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 job_valid,
    output logic                      job_ready,
    input  wire ucbsel_pkg::job_t     job,
    input  wire logic [15:0]          gain,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ucbsel_pkg::result_beat_t  m_data
);
    import ucbsel_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXPLOIT, ST_NORM, ST_SQUARE, ST_ADJUST, ST_LN,
        ST_RATIO_GO, ST_RATIO, ST_SQRT, ST_EXPLORE, ST_SUM, ST_UPDATE
    } state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic signed [32:0]  exploit_reg;
    logic [31:0]         x_reg;
    logic [63:0]         sq_reg;
    logic [19:0]         lg_reg;
    logic [3:0]          bit_reg;
    logic [19:0]         ln_reg;
    logic [35:0]         v_reg;
    logic [35:0]         res_reg;
    logic [35:0]         one_reg;
    logic [21:0]         explore_reg;
    logic signed [31:0]  score_reg;
    logic signed [31:0]  best_score_reg;
    logic [IDX_W-1:0]    best_index_reg;
    logic                best_unvisited_reg;
    logic                m_valid_reg;
    result_beat_t        m_data_reg;

    logic                div_start;
    logic [31:0]         div_dividend;
    logic [15:0]         div_divisor;
    logic                div_done;
    logic [31:0]         div_quotient;
    logic [15:0]         wins_mag;
    logic [3:0]          top;
    logic [32:0]         sq_top;
    logic [35:0]         trial;
    logic [51:0]         ln_prod;
    logic [33:0]         gain_prod;
    logic signed [33:0]  sum;
    logic                better;
    result_beat_t        best_next;
    logic                out_free;
    logic                emit;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (state_reg == ST_UPDATE) && job_reg.beat.last_child && out_free;

    always_comb begin
        wins_mag = job.beat.child_wins[15] ? 16'(-job.beat.child_wins)
                                           : job.beat.child_wins;
        div_start = (state_reg == ST_IDLE && job_valid && job.compare_en && !job.unvisited)
                 || (state_reg == ST_RATIO_GO);
        if (state_reg == ST_IDLE) begin
            div_dividend = {wins_mag, 16'd0};
            div_divisor  = job.beat.child_visits;
        end else begin
            div_dividend = {12'd0, ln_reg};
            div_divisor  = job_reg.beat.child_visits;
        end
    end

    ucbsel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        top = '0;
        for (int i = 1; i < 16; i++) begin
            if (job_reg.beat.parent_visits[i]) begin
                top = 4'(i);
            end
        end
        sq_top    = sq_reg[63:31];
        trial     = res_reg + one_reg;
        ln_prod   = lg_reg * LN2_Q32;
        gain_prod = gain * res_reg[17:0];
        sum       = 34'(exploit_reg) + $signed({12'd0, explore_reg});
        better    = job_reg.compare_en && (score_reg > best_score_reg);
        best_next.best_score     = better ? score_reg : best_score_reg;
        best_next.best_index     = better ? job_reg.position : best_index_reg;
        best_next.best_unvisited = better ? job_reg.unvisited : best_unvisited_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            best_score_reg     <= THRESHOLD_START;
            best_index_reg     <= '0;
            best_unvisited_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        if (!job.compare_en) begin
                            state_reg <= ST_UPDATE;
                        end else if (job.unvisited) begin
                            score_reg <= SCORE_MAX;
                            state_reg <= ST_UPDATE;
                        end else begin
                            state_reg <= ST_EXPLOIT;
                        end
                    end
                end
                ST_EXPLOIT: begin
                    if (div_done) begin
                        exploit_reg <= job_reg.beat.child_wins[15]
                                     ? -$signed({1'b0, div_quotient})
                                     : $signed({1'b0, div_quotient});
                        if (job_reg.small_parent) begin
                            explore_reg <= '0;
                            state_reg   <= ST_SUM;
                        end else begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    x_reg     <= {16'd0, job_reg.beat.parent_visits} << (5'd31 - {1'b0, top});
                    lg_reg    <= {top, 16'd0};
                    bit_reg   <= 4'd15;
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    sq_reg    <= x_reg * x_reg;
                    state_reg <= ST_ADJUST;
                end
                ST_ADJUST: begin
                    if (sq_top[32]) begin
                        x_reg           <= sq_top[32:1];
                        lg_reg[bit_reg] <= 1'b1;
                    end else begin
                        x_reg <= sq_top[31:0];
                    end
                    bit_reg   <= bit_reg - 4'd1;
                    state_reg <= (bit_reg == 4'd0) ? ST_LN : ST_SQUARE;
                end
                ST_LN: begin
                    ln_reg    <= ln_prod[51:32];
                    state_reg <= ST_RATIO_GO;
                end
                ST_RATIO_GO: begin
                    state_reg <= ST_RATIO;
                end
                ST_RATIO: begin
                    if (div_done) begin
                        v_reg     <= {div_quotient[19:0], 16'd0};
                        res_reg   <= '0;
                        one_reg   <= 36'd1 << 34;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (v_reg >= trial) begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + one_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    one_reg <= one_reg >> 2;
                    if (one_reg == 36'd1) begin
                        state_reg <= ST_EXPLORE;
                    end
                end
                ST_EXPLORE: begin
                    explore_reg <= gain_prod[33:12];
                    state_reg   <= ST_SUM;
                end
                ST_SUM: begin
                    score_reg <= (sum > 34'(SCORE_MAX)) ? SCORE_MAX : sum[31:0];
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (!job_reg.beat.last_child) begin
                        best_score_reg     <= best_next.best_score;
                        best_index_reg     <= best_next.best_index;
                        best_unvisited_reg <= best_next.best_unvisited;
                        state_reg          <= ST_IDLE;
                    end else if (out_free) begin
                        m_data_reg         <= best_next;
                        best_score_reg     <= THRESHOLD_START;
                        best_index_reg     <= '0;
                        best_unvisited_reg <= 1'b0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ucb1_child_select_core.sv -----
// UCB1 child selection core. Children of one parent stream in as beats on the
// s_ channel; the index, unvisited flag and Q16.16 score of the best child leave
// on the m_ channel after the beat marked last_child. A two-beat queue takes in
// beats while the scoring sequencer works. A visited child with a parent count of
// two or more passes twice through the shared radix-2 divider, with mantissa
// squaring for the logarithm between, then a square root and the explore, sum
// and update steps. For a parent count below two it takes the first division,
// sum and update only; an unvisited child or one past the 64th of its run goes
// straight to update. A last child also waits while an earlier result beat is
// still held on the m_ channel. The exploration gain register is written through
// the cfg_ channel, which is always ready, and should only be written while the block is idle.
`default_nettype none
module ucb1_child_select_core (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire ucbsel_pkg::child_beat_t s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output ucbsel_pkg::result_beat_t     m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [15:0]             cfg_data
);
    import ucbsel_pkg::*;

    logic [15:0] gain_reg;
    logic        job_valid;
    logic        job_ready;
    job_t        job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid) begin
            gain_reg <= cfg_data;
        end
    end

    ucbsel_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    ucbsel_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .gain      (gain_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ----- hdl/ucbsel_checker.sv -----
// port-level checks for the ucb1 child selection core and their binding
`default_nettype none
module ucbsel_checker (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire ucbsel_pkg::result_beat_t m_data
);
    import ucbsel_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before acceptance");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    a_unvisited_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.best_unvisited |-> m_data.best_score == SCORE_MAX)
        else $error("unvisited winner without saturated score");

    a_above_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.best_score >= THRESHOLD_START)
        else $error("best score below starting threshold");

endmodule

bind ucb1_child_select_core ucbsel_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
